>>> design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ADDR_W       = 32;
  localparam int PAGE_COUNT_W = 19;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_ALLOCATED     = 3'd0,
    ST_OUT_OF_PAGES  = 3'd1,
    ST_FREED         = 3'd2,
    ST_BAD_ADDRESS   = 3'd3,
    ST_NOT_ALLOCATED = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REG_BASE_ADDRESS = 1'b0,
    REG_PAGE_COUNT   = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_CHECK,
    S_FREE_BIT
  } seq_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       base_address;
    logic [PAGE_COUNT_W-1:0] page_count;
  } cfg_t;

endpackage

>>> design/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a used-page bitmap in memory.
// ----------------------------------------------------------------------------
// After reset the bitmap memory is cleared one word per cycle, with in_ready
// low; configuration writes are taken meanwhile. One request is handled at a
// time and in_ready stays low until its result has been taken. The bitmap
// memory is read one word per cycle: an allocate scans the words up to the
// first one with a clear bit (at most BITMAP_WORDS, none when no pages are
// managed); a free reads no word when the address is rejected, else the word
// that holds the page, as the page index is split into word and bit by a
// shift and a mask, so WORD_BITS must be a power of two. Each result carries
// the free-page count after the request.
module bitmap_page_allocator #(
  parameter int BITMAP_WORDS = 4096,
  parameter int WORD_BITS    = 64,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0]       paddr,
  input  logic [bpa_pkg::PDATA_W-1:0]       pwdata,
  output logic [bpa_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [bpa_pkg::ADDR_W-1:0]        address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpa_pkg::ADDR_W-1:0]        page_address,
  output logic [2:0]                        status,
  output logic [bpa_pkg::PAGE_COUNT_W-1:0]  free_count
);
  import bpa_pkg::*;

  localparam int WA_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  cfg_t                 cfg;
  status_t              status_q;
  logic                 ram_we;
  logic [WA_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WA_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign status = status_q;

  bpa_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpa_bitmap_ram #(
    .DEPTH (BITMAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (WA_W)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_seq #(
    .BITMAP_WORDS (BITMAP_WORDS),
    .WORD_BITS    (WORD_BITS),
    .PAGE_SHIFT   (PAGE_SHIFT),
    .WA_W         (WA_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action_t'(action)),
    .address      (address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .page_address (page_address),
    .status       (status_q),
    .free_count   (free_count),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

endmodule

>>> design/bpa_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpa_cfg_regs
// APB register file holding the managed region base and page count.
// ----------------------------------------------------------------------------
module bpa_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0]  paddr,
  input  logic [bpa_pkg::PDATA_W-1:0]  pwdata,
  output logic [bpa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output bpa_pkg::cfg_t                cfg
);
  import bpa_pkg::*;

  reg_index_t reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BASE_ADDRESS: cfg.base_address <= pwdata;
        REG_PAGE_COUNT:   cfg.page_count   <= pwdata[PAGE_COUNT_W-1:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE_ADDRESS: prdata = cfg.base_address;
      REG_PAGE_COUNT:   prdata = PDATA_W'(cfg.page_count);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> design/bpa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bpa_bitmap_ram
// Used-page bitmap memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpa_bitmap_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 64,
  parameter int AW     = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/bpa_seq.sv
// ----------------------------------------------------------------------------
// bpa_seq
// Request sequencer: bitmap clearing, first-fit word scan, free address
// check and word lookup, used-page count and result register.
// ----------------------------------------------------------------------------
module bpa_seq #(
  parameter int BITMAP_WORDS = 4096,
  parameter int WORD_BITS    = 64,
  parameter int PAGE_SHIFT   = 12,
  parameter int WA_W         = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bpa_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bpa_pkg::action_t                  action,
  input  logic [bpa_pkg::ADDR_W-1:0]        address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpa_pkg::ADDR_W-1:0]        page_address,
  output bpa_pkg::status_t                  status,
  output logic [bpa_pkg::PAGE_COUNT_W-1:0]  free_count,
  output logic                              ram_we,
  output logic [WA_W-1:0]                   ram_waddr,
  output logic [WORD_BITS-1:0]              ram_wdata,
  output logic                              ram_re,
  output logic [WA_W-1:0]                   ram_raddr,
  input  logic [WORD_BITS-1:0]              ram_rdata
);
  import bpa_pkg::*;

  localparam int CAPACITY = BITMAP_WORDS * WORD_BITS;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WC_W     = $clog2(BITMAP_WORDS + 1);
  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int LIM_W    = (CNT_W > PAGE_COUNT_W) ? CNT_W : PAGE_COUNT_W;
  localparam int PI_W     = ADDR_W - PAGE_SHIFT;
  localparam int CMP_W    = (PI_W > LIM_W) ? PI_W : LIM_W;
  localparam logic [LIM_W-1:0]     CAP_LIM = LIM_W'(CAPACITY);
  localparam logic [WORD_BITS-1:0] ONE_BIT = WORD_BITS'(1);
  localparam logic [CNT_W-1:0]     WB_CNT  = CNT_W'(WORD_BITS);

  seq_state_t state, state_next;
  logic [WC_W-1:0]  issue_w, issue_w_next;
  logic [CNT_W-1:0] issue_base, issue_base_next;
  logic [WA_W-1:0]  chk_w, chk_w_next;
  logic [IDX_W-1:0] chk_base, chk_base_next;
  logic [CNT_W-1:0] rem, rem_next;
  logic [ADDR_W-1:0] req_addr;
  logic [PAGE_COUNT_W-1:0] used_count, used_next;

  logic [LIM_W-1:0]        managed;
  logic [ADDR_W-1:0]       abase;
  logic [ADDR_W-1:0]       offset;
  logic [PI_W-1:0]         pidx;
  logic [WA_W-1:0]         pword;
  logic                    bad_addr;
  logic [BIT_W-1:0]        clear_bit;
  logic [IDX_W-1:0]        alloc_idx;
  logic [ADDR_W-1:0]       alloc_addr;
  logic [BIT_W-1:0]        bit_sel;
  logic [PAGE_COUNT_W-1:0] fc;

  logic              res_en;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;

  assign managed  = (LIM_W'(cfg.page_count) < CAP_LIM) ? LIM_W'(cfg.page_count) : CAP_LIM;
  assign abase    = {cfg.base_address[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign offset   = req_addr - abase;
  assign pidx     = offset[ADDR_W-1:PAGE_SHIFT];
  assign pword    = WA_W'(pidx >> BIT_W);
  assign bad_addr = (req_addr < abase) || (|req_addr[PAGE_SHIFT-1:0]) ||
                    (CMP_W'(pidx) >= CMP_W'(managed));
  assign bit_sel  = rem[BIT_W-1:0];
  assign in_ready = (state == S_IDLE) && !out_valid;

  // lowest clear bit of the word under check
  always_comb begin
    clear_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        clear_bit = BIT_W'(i);
      end
    end
  end

  assign alloc_idx  = chk_base + IDX_W'(clear_bit);
  assign alloc_addr = abase + (ADDR_W'(alloc_idx) << PAGE_SHIFT);
  assign fc = (managed > LIM_W'(used_next)) ?
              PAGE_COUNT_W'(managed - LIM_W'(used_next)) : '0;

  always_comb begin
    state_next      = state;
    issue_w_next    = issue_w;
    issue_base_next = issue_base;
    chk_w_next      = chk_w;
    chk_base_next   = chk_base;
    rem_next        = rem;
    used_next       = used_count;
    ram_we          = 1'b0;
    ram_waddr       = chk_w;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = issue_w[WA_W-1:0];
    res_en          = 1'b0;
    res_addr        = '0;
    res_status      = ST_OUT_OF_PAGES;
    unique case (state)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = issue_w[WA_W-1:0];
        ram_wdata    = '0;
        issue_w_next = issue_w + WC_W'(1);
        if (issue_w == WC_W'(BITMAP_WORDS - 1)) begin
          issue_w_next = '0;
          state_next   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (action == ACT_FREE) begin
            state_next = S_FREE_CHECK;
          end else if (managed == '0) begin
            res_en = 1'b1;
          end else begin
            ram_re          = 1'b1;
            ram_raddr       = '0;
            chk_w_next      = '0;
            chk_base_next   = '0;
            issue_w_next    = WC_W'(1);
            issue_base_next = WB_CNT;
            state_next      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ram_rdata != '1) begin
          state_next = S_IDLE;
          res_en     = 1'b1;
          if (LIM_W'(alloc_idx) < managed) begin
            ram_we     = 1'b1;
            ram_wdata  = ram_rdata | (ONE_BIT << clear_bit);
            used_next  = used_count + PAGE_COUNT_W'(1);
            res_addr   = alloc_addr;
            res_status = ST_ALLOCATED;
          end
        end else if (issue_w < WC_W'(BITMAP_WORDS) && LIM_W'(issue_base) < managed) begin
          ram_re          = 1'b1;
          chk_w_next      = issue_w[WA_W-1:0];
          chk_base_next   = issue_base[IDX_W-1:0];
          issue_w_next    = issue_w + WC_W'(1);
          issue_base_next = issue_base + WB_CNT;
        end else begin
          state_next = S_IDLE;
          res_en     = 1'b1;
        end
      end
      S_FREE_CHECK: begin
        if (bad_addr) begin
          state_next = S_IDLE;
          res_en     = 1'b1;
          res_status = ST_BAD_ADDRESS;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = pword;
          chk_w_next = pword;
          rem_next   = CNT_W'(pidx);
          state_next = S_FREE_BIT;
        end
      end
      S_FREE_BIT: begin
        state_next = S_IDLE;
        res_en     = 1'b1;
        if (ram_rdata[bit_sel]) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata & ~(ONE_BIT << bit_sel);
          res_status = ST_FREED;
          if (used_count != '0) begin
            used_next = used_count - PAGE_COUNT_W'(1);
          end
        end else begin
          res_status = ST_NOT_ALLOCATED;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      issue_w    <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      issue_w    <= issue_w_next;
      used_count <= used_next;
      if (res_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_base <= issue_base_next;
    chk_w      <= chk_w_next;
    chk_base   <= chk_base_next;
    rem        <= rem_next;
    if (in_valid && in_ready) begin
      req_addr <= address;
    end
    if (res_en) begin
      page_address <= res_addr;
      status       <= res_status;
      free_count   <= fc;
    end
  end

endmodule
